@@ rtl/cpgs_pkg.sv @@
package cpgs_pkg;

   localparam int DataW    = 24;   // angle, rate and setpoint width
   localparam int ErrW     = 25;   // loop error width
   localparam int DiffW    = 26;   // last error minus error
   localparam int GainW    = 24;
   localparam int LimW     = 15;
   localparam int DriveW   = 16;
   localparam int ProdW    = GainW + 1 + DiffW;
   localparam int AccW     = 54;
   localparam int FracW    = 24;   // fraction bits of a product
   localparam int CsrAddrW = 5;
   localparam int CsrDataW = 32;

   localparam int IntegralLimitDefault = 500;

   typedef enum logic [2:0] {
      REG_TARGET,
      REG_ANGLE_KP,
      REG_ANGLE_KI,
      REG_ANGLE_KD,
      REG_RATE_KP,
      REG_RATE_KI,
      REG_RATE_KD,
      REG_LIMIT
   } reg_index_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_P,
      MUL_I,
      MUL_D
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD,
      ACC_CLAMP,
      ACC_DRIVE
   } acc_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_LOOP,
      SEQ_DONE
   } seq_op_type;

   typedef struct packed {
      logic        err_ld;
      logic        st_upd;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        sp_ld;
      logic        out_ld;
      seq_op_type  seq;
   } ucode_type;

   typedef struct packed {
      logic        err_ld;
      logic        st_upd;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        sp_ld;
      logic        out_ld;
      logic        inner;
   } ctrl_type;

   localparam int UcodeLen = 10;
   localparam int StepW    = $clog2(UcodeLen);

   // steps 0..6 run once per loop, 7..9 form the drive
   localparam ucode_type Ucode [UcodeLen] = '{
      '{1'b1, 1'b0, MUL_NONE, ACC_HOLD,  1'b0, 1'b0, SEQ_NEXT},  // load error
      '{1'b0, 1'b1, MUL_P,    ACC_CLEAR, 1'b0, 1'b0, SEQ_NEXT},  // state update, kp*e
      '{1'b0, 1'b0, MUL_I,    ACC_ADD,   1'b0, 1'b0, SEQ_NEXT},  // ki*integral
      '{1'b0, 1'b0, MUL_D,    ACC_ADD,   1'b0, 1'b0, SEQ_NEXT},  // kd*difference
      '{1'b0, 1'b0, MUL_NONE, ACC_ADD,   1'b0, 1'b0, SEQ_NEXT},
      '{1'b0, 1'b0, MUL_NONE, ACC_CLAMP, 1'b0, 1'b0, SEQ_NEXT},
      '{1'b0, 1'b0, MUL_NONE, ACC_HOLD,  1'b1, 1'b0, SEQ_LOOP},  // setpoint, rerun inner
      '{1'b0, 1'b0, MUL_NONE, ACC_DRIVE, 1'b0, 1'b0, SEQ_NEXT},
      '{1'b0, 1'b0, MUL_NONE, ACC_CLAMP, 1'b0, 1'b0, SEQ_NEXT},
      '{1'b0, 1'b0, MUL_NONE, ACC_HOLD,  1'b0, 1'b1, SEQ_DONE}
   };

endpackage

@@ rtl/cpgs_seq.sv @@
module cpgs_seq
   import cpgs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     out_free,
   output logic     busy,
   output ctrl_type ctrl
);

   logic [StepW-1:0] step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             inner_ff, inner_in;
   ucode_type        uc;

   assign uc = Ucode[step_ff];

   always_comb begin
      step_in  = step_ff;
      busy_in  = busy_ff;
      inner_in = inner_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in  = 1'b1;
            step_in  = '0;
            inner_in = 1'b0;
         end
      end else begin
         case (uc.seq)
            SEQ_NEXT: step_in = step_ff + 1'b1;
            SEQ_LOOP: begin
               if (!inner_ff) begin
                  inner_in = 1'b1;
                  step_in  = '0;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
            SEQ_DONE: begin
               // wait here until the result register is free
               if (out_free) begin
                  busy_in = 1'b0;
                  step_in = '0;
               end
            end
            default: begin
               busy_in = 1'b0;
               step_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         busy_ff  <= 1'b0;
         inner_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         busy_ff  <= busy_in;
         inner_ff <= inner_in;
      end
   end

   always_comb begin
      ctrl.err_ld  = busy_ff && uc.err_ld;
      ctrl.st_upd  = busy_ff && uc.st_upd;
      ctrl.mul_sel = busy_ff ? uc.mul_sel : MUL_NONE;
      ctrl.acc_op  = busy_ff ? uc.acc_op : ACC_HOLD;
      ctrl.sp_ld   = busy_ff && uc.sp_ld && !inner_ff;
      ctrl.out_ld  = busy_ff && uc.out_ld && out_free;
      ctrl.inner   = inner_ff;
   end

   assign busy = busy_ff;

endmodule

@@ rtl/cascaded_pid_gyro_stabilizer.sv @@
// a new req transfer is accepted only once the previous result is loaded for rsp
// the 10-step microprogram runs over one shared 25x26 multiplier
//   (7 steps per loop, 3 for the drive)
// a held rsp transfer stalls the last step until the output register frees
// reset: synchronous, active high; target, gains and limit return to defaults,
//   last loop errors and integrals clear to zero
module cascaded_pid_gyro_stabilizer
   import cpgs_pkg::*;
#(
   parameter int INTEGRAL_LIMIT = IntegralLimitDefault
) (
   input  logic                clock,
   input  logic                reset,
   // input stream
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [47:0]         req_tdata,    // measured_angle[23:0], measured_rate[47:24]
   // result stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,    // drive_value[15:0], rate_setpoint[39:16]
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   // integral clamp in Q16.8 and the width it needs
   localparam int IntLim = INTEGRAL_LIMIT * 256;
   localparam int IntW   = $clog2(IntLim + 1) + 1;
   localparam int SumW   = ErrW + 1;
   localparam logic signed [SumW-1:0] IntLimS = SumW'(IntLim);
   localparam logic signed [IntW-1:0] IntLimI = IntW'(IntLim);

   // configuration registers
   logic signed [DataW-1:0] target_ff;
   logic [GainW-1:0]        angle_kp_ff, angle_ki_ff, angle_kd_ff;
   logic [GainW-1:0]        rate_kp_ff, rate_ki_ff, rate_kd_ff;
   logic [LimW-1:0]         limit_ff;

   // sample and loop state
   logic signed [DataW-1:0] angle_ff, rate_ff;
   logic signed [ErrW-1:0]  err_ff, err_in;
   logic signed [DiffW-1:0] diff_ff, diff_in;
   logic signed [ErrW-1:0]  a_last_ff, r_last_ff, last_cur;
   logic signed [IntW-1:0]  a_integ_ff, r_integ_ff, integ_cur, integ_in;
   logic signed [SumW-1:0]  integ_sum;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic signed [AccW-1:0]  acc_ff, acc_in;
   logic signed [DataW-1:0] sp_ff;

   // result register
   logic                    rsp_valid_ff;
   logic [DriveW-1:0]       drive_ff;
   logic [DataW-1:0]        rsp_sp_ff;

   logic                    start, busy, out_free, csr_wr;
   ctrl_type                ctrl;
   reg_index_type           csr_idx;

   logic [GainW-1:0]        mul_a;
   logic signed [DiffW-1:0] mul_b;
   logic signed [AccW-1:0]  lim_acc, sp_shift, acc_clamp, acc_rnd16, acc_rnd24;

   // one sample in flight; a finished result may wait on rsp meanwhile
   assign req_tready = !busy;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   cpgs_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   // ---------------------------------------------------------------
   // register port: writes land on the access phase
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= -24'sd1664;
         angle_kp_ff <= 24'd1343488;
         angle_ki_ff <= 24'd0;
         angle_kd_ff <= 24'd2621440;
         rate_kp_ff  <= 24'd471859;
         rate_ki_ff  <= 24'd5243;
         rate_kd_ff  <= 24'd983040;
         limit_ff    <= 15'd5000;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_TARGET:   target_ff   <= $signed(csr_pwdata[DataW-1:0]);
            REG_ANGLE_KP: angle_kp_ff <= csr_pwdata[GainW-1:0];
            REG_ANGLE_KI: angle_ki_ff <= csr_pwdata[GainW-1:0];
            REG_ANGLE_KD: angle_kd_ff <= csr_pwdata[GainW-1:0];
            REG_RATE_KP:  rate_kp_ff  <= csr_pwdata[GainW-1:0];
            REG_RATE_KI:  rate_ki_ff  <= csr_pwdata[GainW-1:0];
            REG_RATE_KD:  rate_kd_ff  <= csr_pwdata[GainW-1:0];
            REG_LIMIT:    limit_ff    <= csr_pwdata[LimW-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_TARGET:   csr_prdata = {8'd0, target_ff};
         REG_ANGLE_KP: csr_prdata = {8'd0, angle_kp_ff};
         REG_ANGLE_KI: csr_prdata = {8'd0, angle_ki_ff};
         REG_ANGLE_KD: csr_prdata = {8'd0, angle_kd_ff};
         REG_RATE_KP:  csr_prdata = {8'd0, rate_kp_ff};
         REG_RATE_KI:  csr_prdata = {8'd0, rate_ki_ff};
         REG_RATE_KD:  csr_prdata = {8'd0, rate_kd_ff};
         REG_LIMIT:    csr_prdata = {17'd0, limit_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // sample capture
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (start) begin
         angle_ff <= $signed(req_tdata[23:0]);
         rate_ff  <= $signed(req_tdata[47:24]);
      end
   end

   // ---------------------------------------------------------------
   // loop error and state update, shared by both loops
   // ---------------------------------------------------------------
   // outer: target minus angle; inner: setpoint plus raw rate (rate negated twice)
   assign err_in = ctrl.inner ? ({sp_ff[DataW-1], sp_ff} + {rate_ff[DataW-1], rate_ff})
                              : ({target_ff[DataW-1], target_ff}
                                 - {angle_ff[DataW-1], angle_ff});

   assign integ_cur = ctrl.inner ? r_integ_ff : a_integ_ff;
   assign last_cur  = ctrl.inner ? r_last_ff : a_last_ff;
   assign integ_sum = SumW'(integ_cur) + SumW'(err_ff);

   // integral held to plus or minus the limit
   always_comb begin
      if (integ_sum > IntLimS) begin
         integ_in = IntLimI;
      end else if (integ_sum < -IntLimS) begin
         integ_in = -IntLimI;
      end else begin
         integ_in = IntW'(integ_sum);
      end
   end

   // difference term as previous minus current error
   assign diff_in = DiffW'(last_cur) - DiffW'(err_ff);

   always_ff @(posedge clock) begin
      if (ctrl.err_ld) begin
         err_ff <= err_in;
      end
      if (ctrl.st_upd) begin
         diff_ff <= diff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_last_ff  <= '0;
         r_last_ff  <= '0;
         a_integ_ff <= '0;
         r_integ_ff <= '0;
      end else if (ctrl.st_upd) begin
         if (ctrl.inner) begin
            r_last_ff  <= err_ff;
            r_integ_ff <= integ_in;
         end else begin
            a_last_ff  <= err_ff;
            a_integ_ff <= integ_in;
         end
      end
   end

   // ---------------------------------------------------------------
   // shared multiplier: unsigned gain times signed operand
   // ---------------------------------------------------------------
   always_comb begin
      case (ctrl.mul_sel)
         MUL_P: begin
            mul_a = ctrl.inner ? rate_kp_ff : angle_kp_ff;
            mul_b = DiffW'(err_ff);
         end
         MUL_I: begin
            // integral was updated on the step before
            mul_a = ctrl.inner ? rate_ki_ff : angle_ki_ff;
            mul_b = DiffW'(integ_cur);
         end
         MUL_D: begin
            mul_a = ctrl.inner ? rate_kd_ff : angle_kd_ff;
            mul_b = diff_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = $signed({1'b0, mul_a}) * mul_b;

   always_ff @(posedge clock) begin
      if (ctrl.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
      end
   end

   // ---------------------------------------------------------------
   // accumulator in Q.24
   // ---------------------------------------------------------------
   assign lim_acc  = $signed({{(AccW - LimW - FracW){1'b0}}, limit_ff, {FracW{1'b0}}});
   // half the setpoint in Q.24: Q16.8 shifted up by 15
   assign sp_shift = $signed({{(AccW - DataW - 15){sp_ff[DataW-1]}}, sp_ff, 15'd0});

   always_comb begin
      if (acc_ff > lim_acc) begin
         acc_clamp = lim_acc;
      end else if (acc_ff < -lim_acc) begin
         acc_clamp = -lim_acc;
      end else begin
         acc_clamp = acc_ff;
      end
   end

   always_comb begin
      case (ctrl.acc_op)
         ACC_CLEAR: acc_in = '0;
         ACC_ADD:   acc_in = acc_ff + AccW'(prod_ff);
         ACC_CLAMP: acc_in = acc_clamp;
         ACC_DRIVE: acc_in = acc_ff + sp_shift;
         default:   acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // truncation toward zero: bias negative values before the shift
   assign acc_rnd16 = acc_ff + $signed({{(AccW - 16){1'b0}}, {16{acc_ff[AccW-1]}}});
   assign acc_rnd24 = acc_ff + $signed({{(AccW - FracW){1'b0}}, {FracW{acc_ff[AccW-1]}}});

   always_ff @(posedge clock) begin
      if (ctrl.sp_ld) begin
         sp_ff <= acc_rnd16[16 + DataW - 1:16];
      end
   end

   // ---------------------------------------------------------------
   // result register, frees as soon as the transfer completes
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.out_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_ld) begin
         drive_ff  <= acc_rnd24[FracW + DriveW - 1:FracW];
         rsp_sp_ff <= sp_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_sp_ff, drive_ff};

`ifndef ASSERT_OFF
   a_angle_integ_bound : assert property (@(posedge clock) disable iff (reset)
      (a_integ_ff <= IntLimI) && (a_integ_ff >= -IntLimI))
      else $error("outer integral beyond limit");

   a_rate_integ_bound : assert property (@(posedge clock) disable iff (reset)
      (r_integ_ff <= IntLimI) && (r_integ_ff >= -IntLimI))
      else $error("inner integral beyond limit");

   a_clamp_holds : assert property (@(posedge clock) disable iff (reset)
      (ctrl.acc_op == ACC_CLAMP) |=>
         ((acc_ff <= $past(lim_acc)) && (acc_ff >= -$past(lim_acc))))
      else $error("accumulator outside output limit after clamp");

   a_result_shown : assert property (@(posedge clock) disable iff (reset)
      ctrl.out_ld |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> (busy && !req_tready))
      else $error("sequencer did not start on accepted sample");
`endif

endmodule
